FILE: design/iae_pkg.sv
// Shared types and encodings for the immediate ALU execute block.
package iae_pkg;

    localparam int unsigned XLEN      = 64;
    localparam int unsigned REG_COUNT = 32;
    localparam int unsigned REG_IDX_W = 5;

    // Operation selector on the input word
    localparam logic FUNC_EXEC = 1'b0;
    localparam logic FUNC_LOAD = 1'b1;

    // Instruction class field, bits 28:23
    localparam logic [5:0] CLS_ADDSUB_IMM = 6'h22;
    localparam logic [5:0] CLS_LOGIC_IMM  = 6'h24;

    // Logical immediate opc field, bits 30:29
    typedef enum logic [1:0] {
        OPC_AND  = 2'b00,
        OPC_ORR  = 2'b01,
        OPC_EOR  = 2'b10,
        OPC_ANDS = 2'b11
    } logic_opc_t;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } nzcv_t;

    // Outcome of one executed word
    typedef struct packed {
        logic [REG_IDX_W-1:0] dest;
        logic [XLEN-1:0]      value;
        logic                 write;
        logic                 undef;
        logic                 flags_we;
        nzcv_t                flags;
    } exec_res_t;

endpackage

FILE: design/iae_bitmask.sv
// Bitmask immediate decoder for logical-immediate instructions.
module iae_bitmask
    import iae_pkg::*;
(
    input  logic            nbit,
    input  logic [5:0]      immr,
    input  logic [5:0]      imms,
    output logic [XLEN-1:0] mask,
    output logic            reserved
);

    localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};

    logic [6:0]      combined;
    logic [2:0]      len;
    logic [6:0]      esize;
    logic [5:0]      levels;
    logic [5:0]      s_val;
    logic [5:0]      r_val;
    logic [XLEN-1:0] emask;
    logic [XLEN-1:0] welem;
    logic [XLEN-1:0] rot;

    // Element size from the highest set bit of {N, ~imms}
    always_comb
    begin
        combined = {nbit, ~imms};
        priority if (combined[6]) len = 3'd6;
        else if (combined[5])     len = 3'd5;
        else if (combined[4])     len = 3'd4;
        else if (combined[3])     len = 3'd3;
        else if (combined[2])     len = 3'd2;
        else if (combined[1])     len = 3'd1;
        else                      len = 3'd0;
    end

    assign esize  = 7'd1 << len;
    assign levels = 6'(esize - 7'd1);
    assign s_val  = imms & levels;
    assign r_val  = immr & levels;

    // Run of s+1 ones, rotated right by r inside one element
    assign emask = ~(ALL_ONES << esize);
    assign welem = ~(ALL_ONES << ({1'b0, s_val} + 7'd1));
    assign rot   = ((welem >> r_val) | (welem << (esize - {1'b0, r_val}))) & emask;

    assign reserved = (combined[6:1] == 6'd0) || (s_val == levels);

    // Replicate the element across the word
    always_comb
    begin
        unique case (len)
            3'd1:    mask = {32{rot[1:0]}};
            3'd2:    mask = {16{rot[3:0]}};
            3'd3:    mask = {8{rot[7:0]}};
            3'd4:    mask = {4{rot[15:0]}};
            3'd5:    mask = {2{rot[31:0]}};
            default: mask = rot;
        endcase
    end

endmodule

FILE: design/iae_alu.sv
// Decode and single-pass execute of add/sub and logical immediate words.
module iae_alu
    import iae_pkg::*;
(
    input  logic                 func,
    input  logic [31:0]          instruction,
    input  logic [REG_IDX_W-1:0] load_index,
    input  logic [XLEN-1:0]      load_value,
    input  logic [XLEN-1:0]      rn_value,
    input  nzcv_t                flags_cur,
    output exec_res_t            res
);

    logic            wide;
    logic [5:0]      cls;
    logic [XLEN-1:0] x_op;
    logic [XLEN-1:0] imm_ext;
    logic [XLEN-1:0] y_op;
    logic            sub;
    logic            setf;
    logic [XLEN:0]   sum_w;
    logic [32:0]     sum_n;
    logic [XLEN-1:0] as_value;
    logic            as_c;
    logic            as_v;
    logic [XLEN-1:0] mask;
    logic            mask_rsvd;
    logic [XLEN-1:0] lg_value;
    logic_opc_t      opc;
    logic            lg_undef;
    logic            n_of;

    assign wide = instruction[31];
    assign cls  = instruction[28:23];
    assign sub  = instruction[30];
    assign setf = instruction[29];
    assign opc  = logic_opc_t'(instruction[30:29]);
    assign x_op = wide ? rn_value : {32'd0, rn_value[31:0]};

    // Add/sub immediate through a 64-bit and a 32-bit adder, carry-in for subtract
    assign imm_ext = instruction[22] ? {40'd0, instruction[21:10], 12'd0}
                                     : {52'd0, instruction[21:10]};
    assign y_op    = sub ? ~imm_ext : imm_ext;
    assign sum_w   = {1'b0, x_op} + {1'b0, y_op} + {{XLEN{1'b0}}, sub};
    assign sum_n   = {1'b0, x_op[31:0]} + {1'b0, y_op[31:0]} + {32'd0, sub};

    always_comb
    begin
        if (wide)
        begin
            as_value = sum_w[XLEN-1:0];
            as_c     = sum_w[XLEN];
            as_v     = (x_op[63] ^ sum_w[63]) & (y_op[63] ^ sum_w[63]);
        end
        else
        begin
            as_value = {32'd0, sum_n[31:0]};
            as_c     = sum_n[32];
            as_v     = (x_op[31] ^ sum_n[31]) & (y_op[31] ^ sum_n[31]);
        end
    end

    iae_bitmask u_bitmask (
        .nbit     (instruction[22]),
        .immr     (instruction[21:16]),
        .imms     (instruction[15:10]),
        .mask     (mask),
        .reserved (mask_rsvd)
    );

    // Logic unit
    always_comb
    begin
        unique case (opc)
            OPC_ORR: lg_value = x_op | mask;
            OPC_EOR: lg_value = x_op ^ mask;
            default: lg_value = x_op & mask;
        endcase
        if (!wide)
        begin
            lg_value = {32'd0, lg_value[31:0]};
        end
    end

    assign lg_undef = (!wide && instruction[22]) || mask_rsvd;

    // Result selection and flag update
    always_comb
    begin
        res = '{dest: '0, value: '0, write: 1'b0, undef: 1'b0,
                flags_we: 1'b0, flags: flags_cur};
        n_of = 1'b0;
        if (func == FUNC_LOAD)
        begin
            res.dest  = load_index;
            res.value = load_value;
            res.write = 1'b1;
        end
        else if (cls == CLS_ADDSUB_IMM)
        begin
            res.dest  = instruction[4:0];
            res.value = as_value;
            res.write = 1'b1;
            n_of      = wide ? as_value[63] : as_value[31];
            if (setf)
            begin
                res.flags_we = 1'b1;
                res.flags    = '{n: n_of, z: (as_value == '0), c: as_c, v: as_v};
            end
        end
        else if (cls == CLS_LOGIC_IMM && !lg_undef)
        begin
            res.dest  = instruction[4:0];
            res.value = lg_value;
            res.write = 1'b1;
            n_of      = wide ? lg_value[63] : lg_value[31];
            if (opc == OPC_ANDS)
            begin
                res.flags_we = 1'b1;
                res.flags    = '{n: n_of, z: (lg_value == '0), c: 1'b0, v: 1'b0};
            end
        end
        else
        begin
            res.undef = 1'b1;
        end
    end

endmodule

FILE: design/immediate_alu_execute_top.sv
// Top level: input register, register file, flags and result register.
//
// Executes AArch64 ADD/ADDS/SUB/SUBS (12-bit immediate, optional LSL 12) and
// AND/ORR/EOR/ANDS (bitmask immediate) against a 32 x 64-bit register file
// and NZCV, or loads a register directly when func is 1. One word is taken
// per clock while in_ready is high. An accepted word sits in the input
// register while the adders and logic unit execute it from the register
// file and flags; the edge on which it advances writes the register file and
// flags and loads the result register, so the next word always sees the
// previous write. Once the result register holds an unread word and the input
// register holds the next one, in_ready stays low until the result is taken.
// Register 31 is an ordinary entry. Reset clears the register file and flags
// immediately.
module immediate_alu_execute_top
    import iae_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    input  logic [31:0]          instruction,
    input  logic [REG_IDX_W-1:0] load_index,
    input  logic [XLEN-1:0]      load_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [REG_IDX_W-1:0] dest_index,
    output logic [XLEN-1:0]      result_value,
    output logic                 flag_negative,
    output logic                 flag_zero,
    output logic                 flag_carry,
    output logic                 flag_overflow,
    output logic                 undefined_op,
    output logic                 did_write
);

    logic                 s1_valid_reg;
    logic                 s1_func_reg;
    logic [31:0]          s1_inst_reg;
    logic [REG_IDX_W-1:0] s1_idx_reg;
    logic [XLEN-1:0]      s1_val_reg;
    logic [XLEN-1:0]      rf_reg [REG_COUNT];
    nzcv_t                flags_reg;
    logic                 out_valid_reg;
    exec_res_t            out_res_reg;
    exec_res_t            exec;
    logic                 advance;
    logic                 in_fire;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= func;
            s1_inst_reg <= instruction;
            s1_idx_reg  <= load_index;
            s1_val_reg  <= load_value;
        end
    end

    iae_alu u_alu (
        .func        (s1_func_reg),
        .instruction (s1_inst_reg),
        .load_index  (s1_idx_reg),
        .load_value  (s1_val_reg),
        .rn_value    (rf_reg[s1_inst_reg[9:5]]),
        .flags_cur   (flags_reg),
        .res         (exec)
    );

    // Architectural state: register file and NZCV
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
            flags_reg <= '0;
        end
        else if (advance)
        begin
            if (exec.write)
            begin
                rf_reg[exec.dest] <= exec.value;
            end
            if (exec.flags_we)
            begin
                flags_reg <= exec.flags;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= exec;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dest_index    = out_res_reg.dest;
    assign result_value  = out_res_reg.value;
    assign flag_negative = out_res_reg.flags.n;
    assign flag_zero     = out_res_reg.flags.z;
    assign flag_carry    = out_res_reg.flags.c;
    assign flag_overflow = out_res_reg.flags.v;
    assign undefined_op  = out_res_reg.undef;
    assign did_write     = out_res_reg.write;

    // Checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stage empty but not ready");

    a_undef_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_res_reg.undef && out_res_reg.write))
        else $error("undefined word reported a write");

    a_undef_keeps_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && exec.undef) |=> $stable(flags_reg))
        else $error("undefined word changed flags");

    a_rf_written: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && exec.write) |=> rf_reg[$past(exec.dest)] == $past(exec.value))
        else $error("register file write lost");

    a_out_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_res_reg.flags == flags_reg)
        else $error("reported flags differ from architectural flags");

endmodule

FILE: verif/immediate_alu_execute_top_test.sv
// Testbench for immediate_alu_execute_top: queued word driver, result monitor, shadow ALU.
module immediate_alu_execute_top_test;
    import iae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned  CYCLE_LIMIT   = 200000;
    localparam int unsigned  DRAIN_CYCLES  = 20;
    localparam int unsigned  RANDOM_WORDS  = 750;
    localparam int unsigned  STALL_AT      = 250;
    localparam int unsigned  STALL_CYCLES  = 60;
    localparam int unsigned  CALM_FIRST    = 400;
    localparam int unsigned  CALM_LAST     = 520;
    localparam int unsigned  GAP_PERCENT   = 35;
    localparam logic [5:0]   CLS_ADDSUB_TAGS = 6'h23;

    // One input word as driven on the ports
    typedef struct packed {
        logic            func;
        logic [31:0]     instruction;
        logic [4:0]      load_index;
        logic [63:0]     load_value;
    } alu_word_t;

    // One result word as seen on the ports
    typedef struct packed {
        logic [4:0]      dest;
        logic [63:0]     value;
        nzcv_t           flags;
        logic            undef;
        logic            wrote;
    } writeback_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [31:0] instruction = '0;
    logic [4:0]  load_index = '0;
    logic [63:0] load_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [4:0]  dest_index;
    logic [63:0] result_value;
    logic        flag_negative;
    logic        flag_zero;
    logic        flag_carry;
    logic        flag_overflow;
    logic        undefined_op;
    logic        did_write;

    // Shadow architectural state
    logic [63:0] shadow_gpr [32];
    nzcv_t       shadow_nzcv;

    alu_word_t   pending_words [$];
    writeback_t  pending_writebacks [$];
    alu_word_t   staged_word;
    bit          in_taken = 1'b0;
    int unsigned words_taken = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;

    immediate_alu_execute_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .instruction   (instruction),
        .load_index    (load_index),
        .load_value    (load_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dest_index    (dest_index),
        .result_value  (result_value),
        .flag_negative (flag_negative),
        .flag_zero     (flag_zero),
        .flag_carry    (flag_carry),
        .flag_overflow (flag_overflow),
        .undefined_op  (undefined_op),
        .did_write     (did_write)
    );

    always #5 clk = ~clk;

    // DecodeBitMasks; returns 0 for a reserved pattern
    function automatic bit decode_bitmask(input logic nbit, input logic [5:0] imms,
                                          input logic [5:0] immr, input bit wide,
                                          output logic [63:0] mask);
        logic [6:0]  combined;
        int          len;
        int          esize;
        logic [5:0]  levels;
        logic [5:0]  s;
        logic [5:0]  r;
        logic [63:0] emask;
        logic [63:0] welem;
        logic [63:0] rot;
        logic [63:0] rep;
        combined = {nbit, ~imms};
        len = -1;
        mask = '0;
        for (int i = 6; i >= 0; i--)
        begin
            if (combined[i] && len < 0)
                len = i;
        end
        if (len < 1)
            return 1'b0;
        esize = 1 << len;
        levels = 6'(esize - 1);
        if ((imms & levels) == levels)
            return 1'b0;
        s = imms & levels;
        r = immr & levels;
        emask = (esize == 64) ? '1 : ((64'd1 << esize) - 64'd1);
        welem = (64'd1 << (s + 6'd1)) - 64'd1;
        if (r == 0)
            rot = welem;
        else
            rot = ((welem >> r) | (welem << (esize - r))) & emask;
        rep = '0;
        for (int e = 0; e < 64; e += esize)
        begin
            rep |= rot << e;
        end
        mask = wide ? rep : {32'd0, rep[31:0]};
        return 1'b1;
    endfunction

    // N and Z from the result at the operand width
    function automatic void set_nz(input logic [63:0] value, input bit wide);
        shadow_nzcv.n = wide ? value[63] : value[31];
        shadow_nzcv.z = (value == '0);
    endfunction

    // Execute one word on the shadow state and return what the block should report
    function automatic writeback_t execute_word(input alu_word_t w);
        writeback_t  o;
        logic [4:0]  rd;
        logic [4:0]  rn;
        bit          wide;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] imm;
        logic [63:0] mask;
        logic [64:0] sum;
        logic        cin;
        logic        carry;
        logic        ovf;
        logic_opc_t  opc;
        o = '0;
        if (w.func == FUNC_LOAD)
        begin
            shadow_gpr[w.load_index] = w.load_value;
            o.dest = w.load_index;
            o.value = w.load_value;
            o.wrote = 1'b1;
        end
        else
        begin
            rd = w.instruction[4:0];
            rn = w.instruction[9:5];
            wide = w.instruction[31];
            x = shadow_gpr[rn];
            if (!wide)
                x[63:32] = '0;
            if (w.instruction[28:23] == CLS_ADDSUB_IMM)
            begin
                imm = {52'd0, w.instruction[21:10]};
                if (w.instruction[22])
                    imm = imm << 12;
                cin = w.instruction[30];
                y = cin ? ~imm : imm;
                if (wide)
                begin
                    sum = {1'b0, x} + {1'b0, y} + 65'(cin);
                    o.value = sum[63:0];
                    carry = sum[64];
                    ovf = (x[63] ^ sum[63]) & (y[63] ^ sum[63]);
                end
                else
                begin
                    sum = {33'd0, x[31:0]} + {33'd0, y[31:0]} + 65'(cin);
                    o.value = {32'd0, sum[31:0]};
                    carry = sum[32];
                    ovf = (x[31] ^ sum[31]) & (y[31] ^ sum[31]);
                end
                if (w.instruction[29])
                begin
                    set_nz(o.value, wide);
                    shadow_nzcv.c = carry;
                    shadow_nzcv.v = ovf;
                end
                o.dest = rd;
                o.wrote = 1'b1;
                shadow_gpr[rd] = o.value;
            end
            else if (w.instruction[28:23] == CLS_LOGIC_IMM)
            begin
                opc = logic_opc_t'(w.instruction[30:29]);
                if ((!wide && w.instruction[22]) ||
                    !decode_bitmask(w.instruction[22], w.instruction[15:10],
                                    w.instruction[21:16], wide, mask))
                    o.undef = 1'b1;
                else
                begin
                    case (opc)
                        OPC_ORR: o.value = x | mask;
                        OPC_EOR: o.value = x ^ mask;
                        default: o.value = x & mask;
                    endcase
                    if (!wide)
                        o.value[63:32] = '0;
                    if (opc == OPC_ANDS)
                    begin
                        set_nz(o.value, wide);
                        shadow_nzcv.c = 1'b0;
                        shadow_nzcv.v = 1'b0;
                    end
                    o.dest = rd;
                    o.wrote = 1'b1;
                    shadow_gpr[rd] = o.value;
                end
            end
            else
                o.undef = 1'b1;
        end
        o.flags = shadow_nzcv;
        return o;
    endfunction

    function automatic logic [31:0] enc_addsub(input bit sf, input bit sub, input bit setf,
                                               input bit sh, input logic [11:0] imm12,
                                               input logic [4:0] rn, input logic [4:0] rd);
        return {sf, sub, setf, CLS_ADDSUB_IMM, sh, imm12, rn, rd};
    endfunction

    function automatic logic [31:0] enc_logic(input bit sf, input logic_opc_t opc,
                                              input bit nbit, input logic [5:0] immr,
                                              input logic [5:0] imms,
                                              input logic [4:0] rn, input logic [4:0] rd);
        return {sf, opc, CLS_LOGIC_IMM, nbit, immr, imms, rn, rd};
    endfunction

    // Register values that sit on carry, sign and width boundaries
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return {32'd0, 32'h7FFF_FFFF};
            5: return {32'd0, 32'h8000_0000 | 32'($urandom_range(0, 3))};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic bit quiet_gap();
        return (words_taken < CALM_FIRST || words_taken > CALM_LAST) &&
               ($urandom_range(0, 99) < GAP_PERCENT);
    endfunction

    task automatic queue_load(input logic [4:0] idx, input logic [63:0] value);
        pending_words.push_back('{func: FUNC_LOAD, instruction: $urandom,
                                  load_index: idx, load_value: value});
    endtask

    task automatic queue_exec(input logic [31:0] inst);
        pending_words.push_back('{func: FUNC_EXEC, instruction: inst,
                                  load_index: 5'($urandom), load_value: {$urandom, $urandom}});
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // Sender: next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending_words.size() > 0 && (stall_left > 0 || !quiet_gap()))
            begin
                staged_word = pending_words.pop_front();
                func        <= staged_word.func;
                instruction <= staged_word.instruction;
                load_index  <= staged_word.load_index;
                load_value  <= staged_word.load_value;
                in_valid    <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off to fill the pipe
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!stall_done && words_taken >= STALL_AT)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !quiet_gap();
    end

    // Monitor: predict on input handshake, compare on output handshake
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pending_writebacks.push_back(execute_word('{func: func,
                    instruction: instruction, load_index: load_index,
                    load_value: load_value}));
                words_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (pending_writebacks.size() == 0)
                begin
                    $error("result word with nothing expected");
                    error_count++;
                end
                else
                begin
                    writeback_t want;
                    want = pending_writebacks.pop_front();
                    check_field("dest_index", 64'(want.dest), 64'(dest_index));
                    check_field("result_value", want.value, result_value);
                    check_field("flag_negative", 64'(want.flags.n), 64'(flag_negative));
                    check_field("flag_zero", 64'(want.flags.z), 64'(flag_zero));
                    check_field("flag_carry", 64'(want.flags.c), 64'(flag_carry));
                    check_field("flag_overflow", 64'(want.flags.v), 64'(flag_overflow));
                    check_field("undefined_op", 64'(want.undef), 64'(undefined_op));
                    check_field("did_write", 64'(want.wrote), 64'(did_write));
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned pick;
        bit          sf;
        for (int i = 0; i < 32; i++)
        begin
            shadow_gpr[i] = '0;
        end
        shadow_nzcv = '0;

        // Directed: boundary loads, every operation, undefined encodings
        queue_load(5'd0, '0);
        queue_load(5'd1, '1);
        queue_load(5'd31, 64'h8000_0000_0000_0000);
        queue_load(5'd2, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_load(5'd3, 64'hFFFF_FFFF_7FFF_FFFF);
        queue_exec(enc_addsub(1, 0, 1, 0, 12'd1, 5'd1, 5'd4));     // carry out, zero
        queue_exec(enc_addsub(1, 0, 1, 0, 12'd1, 5'd2, 5'd5));     // signed overflow
        queue_exec(enc_addsub(1, 1, 1, 0, 12'd1, 5'd0, 5'd6));     // borrow, negative
        queue_exec(enc_addsub(0, 0, 1, 0, 12'd1, 5'd3, 5'd8));     // 32-bit overflow
        queue_exec(enc_addsub(0, 1, 1, 1, 12'hFFF, 5'd3, 5'd7));   // 32-bit shifted sub
        queue_exec(enc_addsub(1, 0, 0, 1, 12'hFFF, 5'd31, 5'd9));  // shifted, flags kept
        queue_exec(enc_addsub(0, 1, 0, 0, 12'd0, 5'd1, 5'd10));    // upper half cleared
        queue_exec(enc_addsub(1, 1, 1, 0, 12'd0, 5'd31, 5'd31));   // sub zero, carry set
        queue_exec(enc_logic(1, OPC_AND, 1, 6'd0, 6'd0, 5'd1, 5'd12));
        queue_exec(enc_logic(1, OPC_ORR, 1, 6'd63, 6'd62, 5'd0, 5'd13));
        queue_exec(enc_logic(0, OPC_EOR, 0, 6'd1, 6'b111100, 5'd1, 5'd14));
        queue_exec(enc_logic(1, OPC_ANDS, 0, 6'd1, 6'd0, 5'd1, 5'd15));  // negative
        queue_exec(enc_logic(0, OPC_ANDS, 0, 6'd0, 6'd5, 5'd0, 5'd16));  // zero, C V cleared
        queue_exec(enc_logic(0, OPC_AND, 1, 6'd0, 6'd0, 5'd1, 5'd17));   // sf=0 with N=1
        queue_exec(enc_logic(1, OPC_ORR, 0, 6'd0, 6'b111111, 5'd1, 5'd18)); // no element size
        queue_exec(enc_logic(1, OPC_EOR, 1, 6'd7, 6'b111111, 5'd1, 5'd19)); // imms all ones
        queue_exec(enc_logic(1, OPC_AND, 0, 6'd0, 6'b111110, 5'd1, 5'd20)); // element size 1
        queue_exec({1'b1, 2'b00, CLS_ADDSUB_TAGS, 23'd0});          // add/sub with tags
        queue_exec('0);
        queue_exec('1);

        // Random: mostly well-formed add/sub and logical words over loaded registers
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            pick = $urandom_range(0, 99);
            sf = 1'($urandom_range(0, 1));
            if (pick < 20)
                queue_load(5'($urandom), pick_value());
            else if (pick < 55)
                queue_exec(enc_addsub(sf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)),
                                      ($urandom_range(0, 7) == 0) ? 12'hFFF : 12'($urandom),
                                      5'($urandom), 5'($urandom)));
            else if (pick < 90)
                queue_exec(enc_logic(sf, logic_opc_t'($urandom_range(0, 3)),
                                     sf ? 1'($urandom_range(0, 1))
                                        : ($urandom_range(0, 15) == 0),
                                     6'($urandom), 6'($urandom),
                                     5'($urandom), 5'($urandom)));
            else
                queue_exec($urandom);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() > 0 || in_valid || pending_writebacks.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: sim.f
design/iae_pkg.sv
design/iae_bitmask.sv
design/iae_alu.sv
design/immediate_alu_execute_top.sv
verif/immediate_alu_execute_top_test.sv
